### rtl/core/utf8c_pkg.sv
// Shared types, constants and byte classification for the UTF-8 text checker.
`timescale 1ns / 1ps

package utf8c_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned DUE_W  = 3;

   localparam logic [BYTE_W-1:0] BYTE_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] BYTE_BEL   = 8'h07;
   localparam logic [BYTE_W-1:0] BYTE_BS    = 8'h08;
   localparam logic [BYTE_W-1:0] BYTE_HT    = 8'h09;
   localparam logic [BYTE_W-1:0] BYTE_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] BYTE_FF    = 8'h0C;
   localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] BYTE_ESC   = 8'h1B;
   localparam logic [BYTE_W-1:0] PRINT_LO   = 8'h20;
   localparam logic [BYTE_W-1:0] PRINT_HI   = 8'h7E;
   localparam logic [1:0]        CONT_TAG   = 2'b10;

   // Beat handed from the input register to the state update.
   typedef struct packed {
      logic              go;
      logic [BYTE_W-1:0] data;
   } step_type;

   // Verdict produced when a terminator is processed.
   typedef struct packed {
      logic valid;
      logic is_utf8;
   } verdict_type;

   // Lead byte decode result.
   typedef struct packed {
      logic             bad;
      logic [DUE_W-1:0] due;
   } lead_type;

   function automatic logic is_text_ascii(input logic [BYTE_W-1:0] b);
      logic printable;
      printable = (b >= PRINT_LO) && (b <= PRINT_HI);
      return printable || (b == BYTE_BEL) || (b == BYTE_BS) || (b == BYTE_HT) ||
             (b == BYTE_LF) || (b == BYTE_FF) || (b == BYTE_CR) || (b == BYTE_ESC);
   endfunction

   // Byte with top bit set and no sequence open: count leading ones.
   function automatic lead_type decode_lead(input logic [BYTE_W-1:0] b);
      lead_type r;
      r.bad = 1'b0;
      r.due = '0;
      if (!b[6]) begin
         r.bad = 1'b1;               // bare continuation
      end else if (!b[5]) begin
         r.due = DUE_W'(1);
      end else if (!b[4]) begin
         r.due = DUE_W'(2);
      end else if (!b[3]) begin
         r.due = DUE_W'(3);
      end else if (!b[2]) begin
         r.due = DUE_W'(4);
      end else if (!b[1]) begin
         r.due = DUE_W'(5);
      end else begin
         r.bad = 1'b1;               // 0xFE / 0xFF
      end
      return r;
   endfunction

endpackage

### rtl/core/utf8c_state.sv
// Per-string state (pending follower count, error, multibyte flags) and verdict logic.
`timescale 1ns / 1ps

module utf8c_state
   import utf8c_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  step_type    step,
   output verdict_type verdict
);

   logic [DUE_W-1:0] due_ff, due_in;
   logic             err_ff, err_in;
   logic             mb_ff,  mb_in;
   lead_type         lead;

   always_comb begin
      lead    = decode_lead(step.data);
      due_in  = due_ff;
      err_in  = err_ff;
      mb_in   = mb_ff;
      verdict.valid   = 1'b0;
      verdict.is_utf8 = !err_ff && mb_ff;
      if (step.go) begin
         if (step.data == BYTE_NUL) begin
            verdict.valid = 1'b1;
            due_in = '0;
            err_in = 1'b0;
            mb_in  = 1'b0;
         end else if (!err_ff) begin
            if (due_ff != '0) begin
               if (step.data[7:6] != CONT_TAG) begin
                  err_in = 1'b1;
                  due_in = '0;
               end else begin
                  due_in = due_ff - DUE_W'(1);
                  if (due_ff == DUE_W'(1)) begin
                     mb_in = 1'b1;
                  end
               end
            end else if (!step.data[7]) begin
               if (!is_text_ascii(step.data)) begin
                  err_in = 1'b1;
               end
            end else begin
               err_in = lead.bad;
               due_in = lead.due;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         due_ff <= '0;
         err_ff <= 1'b0;
         mb_ff  <= 1'b0;
      end else begin
         due_ff <= due_in;
         err_ff <= err_in;
         mb_ff  <= mb_in;
      end
   end

endmodule

### rtl/core/utf8_text_stream_checker.sv
// Top level: input register, string state update and verdict output register.
//
// Usage:
//  - Input channel req_*: one string byte per beat on req_data_byte. A zero
//    byte terminates the string. Beat accepted when req_valid && !req_stall.
//  - Result channel rsp_*: one beat per terminator, rsp_is_utf8 = 1 when the
//    string had no error and at least one completed multibyte sequence.
//  - Throughput: one byte per cycle, sustained, unless a terminator waits on
//    a stalled result register. The only per-byte work is a 3-bit follower
//    counter and two flags. An accepted terminator passes from the input
//    register to the result register, which drives its verdict on rsp_*.
//  - Stall: while rsp_stall holds a pending verdict, non-zero bytes keep
//    flowing; only a second terminator waits in the input register, and then
//    req_stall is raised until the result register frees up.
//  - Reset (synchronous, active high): empties both registers and clears the
//    per-string state, as if a terminator had just been processed.
`timescale 1ns / 1ps

module utf8_text_stream_checker
   import utf8c_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_is_utf8
);

   // Input register
   logic              in_vld_ff,  in_vld_in;
   logic [BYTE_W-1:0] in_byte_ff;

   // Result register
   logic              out_vld_ff, out_vld_in;
   logic              out_bit_ff;

   logic        out_free;
   logic        s1_go;
   step_type    step;
   verdict_type verdict;

   // Result slot can take a new verdict this cycle.
   assign out_free = !out_vld_ff || !rsp_stall;

   // Data bytes never need the result slot; terminators do.
   assign s1_go = in_vld_ff && ((in_byte_ff != BYTE_NUL) || out_free);

   assign req_stall = in_vld_ff && !s1_go;

   assign step.go   = s1_go;
   assign step.data = in_byte_ff;

   utf8c_state u_state (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .verdict (verdict)
   );

   always_comb begin
      in_vld_in = in_vld_ff;
      if (s1_go) begin
         in_vld_in = 1'b0;
      end
      if (req_valid && !req_stall) begin
         in_vld_in = 1'b1;
      end

      out_vld_in = out_vld_ff;
      if (out_vld_ff && !rsp_stall) begin
         out_vld_in = 1'b0;
      end
      if (verdict.valid) begin
         out_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers, no reset needed.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
      end
      if (verdict.valid) begin
         out_bit_ff <= verdict.is_utf8;
      end
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_is_utf8 = out_bit_ff;

endmodule
